[src/bps_pkg.sv]
// bps_pkg: shared constants, register codes and types of the byte pattern search
// used by every file of the block; depends on nothing
`default_nettype none

package bps_pkg;

    // search geometry
    localparam int MAX_PATTERN   = 32;
    localparam int POS_BITS      = 32;
    localparam int PATTERN_BYTES = 32;
    localparam int DATA_W        = 8;
    localparam int POS_FIELD_W   = 32;
    localparam int LEN_W         = 6;
    localparam int SEEN_W        = $clog2(MAX_PATTERN + 1);
    localparam int SPAN_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PB_IDX_W      = $clog2(PATTERN_BYTES);
    localparam int WORD_W        = 64;
    localparam int NUM_WORDS     = PATTERN_BYTES / 8;

    // config port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCAN_FORWARD   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd5;

    // request queue between front and back (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SEEN_W-1:0]                   active_len;
        logic                                forward;
        logic [PATTERN_BYTES-1:0][DATA_W-1:0] pattern;
    } cfg_t;

    typedef struct packed {
        logic                   found;
        logic                   forward;
        logic [SPAN_W-1:0]      span;
        logic [POS_FIELD_W-1:0] position;
    } entry_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

endpackage

`default_nettype wire

[src/bps_channels.sv]
// bps_channels: valid/ready channel interfaces for scanned bytes and search results
// depends on bps_pkg
`default_nettype none

interface bps_in_if;
    import bps_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [DATA_W-1:0]      data_byte;
    logic [POS_FIELD_W-1:0] byte_position;
    logic                   scan_last;

    modport source (output valid, output data_byte, output byte_position,
                    output scan_last, input ready);
    modport sink   (input valid, input data_byte, input byte_position,
                    input scan_last, output ready);
endinterface

interface bps_out_if;
    import bps_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [POS_FIELD_W-1:0] match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink   (input valid, input found, input match_position, output ready);
endinterface

`default_nettype wire

[src/bps_regs.sv]
// bps_regs: apb register file holding pattern length, direction and pattern words
// depends on bps_pkg
`default_nettype none

module bps_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bps_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bps_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [bps_pkg::APB_DATA_W-1:0] prdata,
    output      logic                           pready,
    output      bps_pkg::cfg_t                  cfg
);
    import bps_pkg::*;

    logic [LEN_W-1:0]  pattern_len_reg;
    logic              scan_forward_reg;
    logic [WORD_W-1:0] pattern_word_reg [NUM_WORDS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg  <= LEN_W'(1);
            scan_forward_reg <= 1'b1;
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                pattern_word_reg[w] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PATTERN_LEN:    pattern_len_reg     <= pwdata[LEN_W-1:0];
                REG_SCAN_FORWARD:   scan_forward_reg    <= pwdata[0];
                REG_PATTERN_WORD_0: pattern_word_reg[0] <= pwdata;
                REG_PATTERN_WORD_1: pattern_word_reg[1] <= pwdata;
                REG_PATTERN_WORD_2: pattern_word_reg[2] <= pwdata;
                REG_PATTERN_WORD_3: pattern_word_reg[3] <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PATTERN_LEN:    prdata = APB_DATA_W'(pattern_len_reg);
            REG_SCAN_FORWARD:   prdata = APB_DATA_W'(scan_forward_reg);
            REG_PATTERN_WORD_0: prdata = pattern_word_reg[0];
            REG_PATTERN_WORD_1: prdata = pattern_word_reg[1];
            REG_PATTERN_WORD_2: prdata = pattern_word_reg[2];
            REG_PATTERN_WORD_3: prdata = pattern_word_reg[3];
            default:            prdata = '0;
        endcase
    end

    // zero length acts as one, oversize clamps to the history depth
    always_comb
    begin
        if (pattern_len_reg == '0)
            cfg.active_len = SEEN_W'(1);
        else if (int'(pattern_len_reg) > MAX_PATTERN)
            cfg.active_len = SEEN_W'(MAX_PATTERN);
        else
            cfg.active_len = SEEN_W'(pattern_len_reg);
        cfg.forward = scan_forward_reg;
        for (int k = 0; k < PATTERN_BYTES; k++)
        begin
            cfg.pattern[k] = pattern_word_reg[k / 8][(k % 8) * 8 +: DATA_W];
        end
    end

endmodule

`default_nettype wire

[src/bps_front.sv]
// bps_front: accepts scanned bytes, keeps the byte history and detects a full match
// depends on bps_pkg and bps_channels
`default_nettype none

module bps_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bps_in_if.sink             scan,
    input  wire bps_pkg::cfg_t cfg,
    input  wire logic          q_full,
    output      logic          push,
    output      bps_pkg::entry_t push_entry
);
    import bps_pkg::*;

    logic [DATA_W-1:0] hist_reg     [MAX_PATTERN];
    logic [DATA_W-1:0] lane_pattern [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] lane_used;
    logic [LEN_W:0]    k_sel [MAX_PATTERN];
    logic [SEEN_W-1:0] seen_reg, seen_inc;
    logic              done_reg;
    logic [MAX_PATTERN-1:0] lane_eq;
    logic              hit;
    logic              accept;

    // pattern byte expected in each history lane, newest byte in lane 0
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            k_sel[j]     = (LEN_W + 1)'(cfg.active_len) - (LEN_W + 1)'(j) - (LEN_W + 1)'(1);
            lane_used[j] = (j < int'(cfg.active_len));
            if (lane_used[j] && (int'(k_sel[j]) < PATTERN_BYTES))
                lane_pattern[j] = cfg.pattern[k_sel[j][PB_IDX_W-1:0]];
            else
                lane_pattern[j] = '0;
        end
    end

    assign scan.ready = !q_full;
    assign accept     = scan.valid && scan.ready;

    // compare against the history as it stands after this byte shifts in
    always_comb
    begin
        lane_eq[0] = (scan.data_byte == lane_pattern[0]) || !lane_used[0];
        for (int j = 1; j < MAX_PATTERN; j++)
        begin
            lane_eq[j] = (hist_reg[j-1] == lane_pattern[j]) || !lane_used[j];
        end
    end

    assign seen_inc = (int'(seen_reg) < MAX_PATTERN) ? seen_reg + SEEN_W'(1) : seen_reg;
    assign hit      = !done_reg && (seen_inc >= cfg.active_len) && (&lane_eq);

    assign push                = accept && !done_reg && (hit || scan.scan_last);
    assign push_entry.found    = hit;
    assign push_entry.forward  = cfg.forward;
    assign push_entry.span     = SPAN_W'(cfg.active_len - SEEN_W'(1));
    assign push_entry.position = scan.byte_position;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            done_reg <= 1'b0;
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                hist_reg[j] <= '0;
            end
        end
        else if (accept)
        begin
            if (scan.scan_last)
            begin
                seen_reg <= '0;
                done_reg <= 1'b0;
                for (int j = 0; j < MAX_PATTERN; j++)
                begin
                    hist_reg[j] <= '0;
                end
            end
            else if (!done_reg)
            begin
                seen_reg    <= seen_inc;
                done_reg    <= hit;
                hist_reg[0] <= scan.data_byte;
                for (int j = 1; j < MAX_PATTERN; j++)
                begin
                    hist_reg[j] <= hist_reg[j-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

[src/bps_queue.sv]
// bps_queue: short fifo of result requests between the front and back halves
// depends on bps_pkg
`default_nettype none

module bps_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire bps_pkg::entry_t push_entry,
    input  wire logic            pop,
    output      bps_pkg::entry_t head,
    output      bps_pkg::q_status_t status
);
    import bps_pkg::*;

    entry_t             q_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + Q_CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - Q_CNT_W'(1);
        end
    end

    assign head         = q_mem[rd_ptr_reg];
    assign status.full  = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

`default_nettype wire

[src/bps_back.sv]
// bps_back: turns queued requests into results, works out the match start position
// depends on bps_pkg and bps_channels
`default_nettype none

module bps_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bps_pkg::entry_t    head,
    input  wire bps_pkg::q_status_t q_status,
    output      logic               pop,
    bps_out_if.source               result
);
    import bps_pkg::*;

    logic                   valid_reg;
    logic                   found_reg;
    logic [POS_FIELD_W-1:0] pos_reg;
    logic [POS_BITS-1:0]    pos_w, span_w, first_w;

    assign pop = !q_status.empty && (!valid_reg || result.ready);

    // start of the match lies span bytes back in scan order
    assign pos_w   = POS_BITS'(head.position);
    assign span_w  = POS_BITS'(head.span);
    assign first_w = head.forward ? pos_w - span_w : pos_w + span_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            found_reg <= head.found;
            pos_reg   <= head.found ? POS_FIELD_W'(first_w) : '0;
        end
    end

    assign result.valid          = valid_reg;
    assign result.found          = found_reg;
    assign result.match_position = pos_reg;

endmodule

`default_nettype wire

[src/byte_pattern_search.sv]
// byte_pattern_search: throughput one byte per cycle while the request queue has room;
// the 32-lane history compare in the front sets that rate; results pass through the queue
// a byte is taken whenever the 2-entry request queue has room, even with a result waiting
// reset clears history, byte count and queue, and loads length 1, forward scan, zero pattern
// depends on bps_pkg, bps_channels, bps_regs, bps_front, bps_queue, bps_back
`default_nettype none

module byte_pattern_search (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    bps_in_if.sink                              scan,
    bps_out_if.source                           result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bps_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bps_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [bps_pkg::APB_DATA_W-1:0] prdata,
    output      logic                           pready
);
    import bps_pkg::*;

    cfg_t      cfg;
    logic      push;
    entry_t    push_entry;
    logic      pop;
    entry_t    head;
    q_status_t q_status;

    // register file: each register at byte address 8 * index
    bps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front: shifts each byte into the history and flags a match or a scan end
    // with no match; once a scan has matched, its remaining bytes are dropped
    bps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan       (scan),
        .cfg        (cfg),
        .q_full     (q_status.full),
        .push       (push),
        .push_entry (push_entry)
    );

    // queue decouples the byte stream from output back-pressure
    bps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // back: computes the first-scanned position and holds the result register
    bps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .result   (result)
    );

    // queue occupancy stays within its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(q_status.count) <= QUEUE_DEPTH)
        else $error("request queue overflow");

    // input stalls only when the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !scan.ready |-> q_status.full)
        else $error("input stalled with queue space left");

    // a pop never happens from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // a not-found result always carries position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.found) |-> (result.match_position == '0))
        else $error("not-found result with nonzero position");

endmodule

`default_nettype wire
